>>> design/bb_pkg.sv
// Shared types and constants for the 3x3 box blur
package bb_pkg;

  localparam int CSUM_W    = 10;
  localparam int WSUM_W    = 12;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // one window column, top row first
  typedef struct packed {
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } column_t;

  typedef struct packed {
    logic top;
    logic bot;
  } row_en_t;

  typedef struct packed {
    logic [CSUM_W-1:0] red;
    logic [CSUM_W-1:0] green;
    logic [CSUM_W-1:0] blue;
  } csum_t;

  typedef struct packed {
    rgb_t pix;
    logic last;
  } result_t;

endpackage

>>> design/box_blur_3x3_rgb.sv
// Streaming 3x3 RGB box blur: line stores, column-cell window, rounding divide
//
//   channel | dir | beat                                   | handshake
//   in_     | in  | command, pixel_red/green/blue           | in_valid / in_stall
//   out_    | out | blur_red/green/blue, frame_last         | out_valid / out_stall
//   cfg_    | in  | cfg_index (0 width, 1 height), cfg_data | cfg_valid / cfg_ready
//
// One input beat per cycle while in_stall is low. A result passes p1, the cells
// and p3 into the queue, which holds 8 results; in_stall rises when that many
// are owed. Line store reads are registered; the divide is one multiply stage.
// Reset (rst_n low, synchronous) clears counters, window and queue; line stores
// are not cleared. A config write restarts the frame counters.
module box_blur_3x3_rgb
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_pixel_red,
  input  logic [7:0]  in_pixel_green,
  input  logic [7:0]  in_pixel_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_blur_red,
  output logic [7:0]  out_blur_green,
  output logic [7:0]  out_blur_blue,
  output logic        out_frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RECIP_W  = 18;
  localparam int RECIP_SH = 18;
  localparam int X_W      = WSUM_W + 1;
  localparam int PROD_W   = X_W + RECIP_W;

  localparam logic CMD_PIXEL        = 1'b0;
  localparam logic CMD_FLUSH        = 1'b1;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic       top_en;
    logic       bot_en;
    logic       left_en;
    logic       right_en;
    logic       last;
    logic [3:0] n;
  } ctl_t;

  typedef struct packed {
    logic [WSUM_W-1:0] red;
    logic [WSUM_W-1:0] green;
    logic [WSUM_W-1:0] blue;
  } wsum_t;

  // ceil(2^18 / 2n) for each possible neighbor count
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
    logic [RECIP_W-1:0] m;
    unique case (n)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

  // (2*sum + n) / (2n), rounded half up
  function automatic logic [7:0] round_avg(input logic [WSUM_W-1:0] s, input logic [3:0] n);
    logic [X_W-1:0]    x;
    logic [PROD_W-1:0] p;
    x = {s, 1'b0} + X_W'(n);
    p = PROD_W'(x) * PROD_W'(recip(n));
    return p[RECIP_SH +: 8];
  endfunction

  logic [10:0]      frame_width_r;
  logic [12:0]      frame_height_r;
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;

  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic             seen1_r, seen1_nxt;
  logic             seen2_r, seen2_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [OUT_CNT_W-1:0] used_r, used_nxt;

  logic             cfg_acc;
  logic             in_acc;
  logic             out_acc;
  logic [COL_W-1:0] col;
  logic             emit;
  ctl_t             ctl;
  rgb_t             in_pix;
  logic [1:0]       rows;
  logic [1:0]       cols;

  logic             p1_vld_r;
  logic             p1_emit_r;
  ctl_t             p1_ctl_r;
  rgb_t             p1_pix_r;
  logic             p2_vld_r;
  ctl_t             p2_ctl_r;
  logic             p3_vld_r;
  wsum_t            p3_sum_r;
  logic [3:0]       p3_n_r;
  logic             p3_last_r;

  rgb_t             lb_top;
  rgb_t             lb_mid;
  column_t          new_col;
  column_t          cell_col [3];
  csum_t            cell_sum [3];
  logic             cell_en  [3];
  row_en_t          row_en;
  wsum_t            win_sum;
  result_t          push_data;
  result_t          out_data;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_stall  = (used_r == OUT_CNT_W'(OUT_DEPTH));
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 11'd1024;
      frame_height_r <= 13'd1024;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[10:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (frame_width_r == '0) begin
      w_last = '0;
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(frame_width_r - 11'd1);
    end
    if (frame_height_r == '0) begin
      h_last = '0;
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last = ROW_W'(frame_height_r - 13'd1);
    end
  end

  always_comb begin
    col    = (in_col_r > w_last) ? '0 : in_col_r;
    emit   = seen2_r || (seen1_r && (col != '0));
    in_pix = (in_command == CMD_PIXEL) ? {in_pixel_red, in_pixel_green, in_pixel_blue}
                                       : '0;

    ctl.top_en   = (out_row_r != '0);
    ctl.bot_en   = (out_row_r != h_last);
    ctl.left_en  = (out_col_r != '0);
    ctl.right_en = (out_col_r != w_last);
    ctl.last     = (out_row_r == h_last) && (out_col_r == w_last);
    rows         = 2'd1 + 2'(ctl.top_en) + 2'(ctl.bot_en);
    cols         = 2'd1 + 2'(ctl.left_en) + 2'(ctl.right_en);
    ctl.n        = 4'(rows) * 4'(cols);
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    seen1_nxt   = seen1_r;
    seen2_nxt   = seen2_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_acc) begin
      in_col_nxt  = '0;
      seen1_nxt   = 1'b0;
      seen2_nxt   = 1'b0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (in_acc) begin
      if (col == w_last) begin
        in_col_nxt = '0;
        seen1_nxt  = 1'b1;
        seen2_nxt  = seen1_r;
      end else begin
        in_col_nxt = col + 1'b1;
      end
      if (emit) begin
        priority if (ctl.last) begin
          in_col_nxt  = '0;
          seen1_nxt   = 1'b0;
          seen2_nxt   = 1'b0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_r == w_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
    end
  end

  assign used_nxt = used_r + OUT_CNT_W'(in_acc && emit) - OUT_CNT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      seen1_r   <= 1'b0;
      seen2_r   <= 1'b0;
      out_col_r <= '0;
      out_row_r <= '0;
      used_r    <= '0;
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      p3_vld_r  <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      seen1_r   <= seen1_nxt;
      seen2_r   <= seen2_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      used_r    <= used_nxt;
      p1_vld_r  <= in_acc;
      p2_vld_r  <= p1_vld_r && p1_emit_r;
      p3_vld_r  <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_emit_r <= emit;
      p1_ctl_r  <= ctl;
      p1_pix_r  <= in_pix;
    end
    p2_ctl_r  <= p1_ctl_r;
    p3_sum_r  <= win_sum;
    p3_n_r    <= p2_ctl_r.n;
    p3_last_r <= p2_ctl_r.last;
  end

  bb_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (col),
    .wr_pix  (in_pix),
    .top_pix (lb_top),
    .mid_pix (lb_mid)
  );

  assign new_col = '{top: lb_top, mid: lb_mid, bot: p1_pix_r};
  assign row_en  = '{top: p2_ctl_r.top_en, bot: p2_ctl_r.bot_en};

  always_comb begin
    cell_en[0] = p2_ctl_r.left_en;
    cell_en[1] = 1'b1;
    cell_en[2] = p2_ctl_r.right_en;
  end

  for (genvar i = 0; i < 3; i++) begin : g_cell
    bb_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (p1_vld_r),
      .col_in  ((i == 2) ? new_col : cell_col[(i + 1) % 3]),
      .row_en  (row_en),
      .col_en  (cell_en[i]),
      .col_out (cell_col[i]),
      .csum    (cell_sum[i])
    );
  end

  always_comb begin
    win_sum.red   = WSUM_W'(cell_sum[0].red)   + WSUM_W'(cell_sum[1].red)
                  + WSUM_W'(cell_sum[2].red);
    win_sum.green = WSUM_W'(cell_sum[0].green) + WSUM_W'(cell_sum[1].green)
                  + WSUM_W'(cell_sum[2].green);
    win_sum.blue  = WSUM_W'(cell_sum[0].blue)  + WSUM_W'(cell_sum[1].blue)
                  + WSUM_W'(cell_sum[2].blue);
  end

  always_comb begin
    push_data.pix.red   = round_avg(p3_sum_r.red,   p3_n_r);
    push_data.pix.green = round_avg(p3_sum_r.green, p3_n_r);
    push_data.pix.blue  = round_avg(p3_sum_r.blue,  p3_n_r);
    push_data.last      = p3_last_r;
  end

  bb_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (p3_vld_r),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_blur_red   = out_data.pix.red;
  assign out_blur_green = out_data.pix.green;
  assign out_blur_blue  = out_data.pix.blue;
  assign out_frame_last = out_data.last;

endmodule

>>> design/bb_cell.sv
// Window column cell: holds three pixels, shifts left, gives a masked column sum
module bb_cell
  import bb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    shift,
  input  column_t col_in,
  input  row_en_t row_en,
  input  logic    col_en,
  output column_t col_out,
  output csum_t   csum
);

  column_t col_r;

  function automatic logic [CSUM_W-1:0] chan_sum(
    input logic [7:0] t,
    input logic [7:0] m,
    input logic [7:0] b,
    input row_en_t    en
  );
    logic [CSUM_W-1:0] acc;
    acc = CSUM_W'(m);
    if (en.top) acc = acc + CSUM_W'(t);
    if (en.bot) acc = acc + CSUM_W'(b);
    return acc;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

  always_comb begin
    csum = '0;
    if (col_en) begin
      csum.red   = chan_sum(col_r.top.red,   col_r.mid.red,   col_r.bot.red,   row_en);
      csum.green = chan_sum(col_r.top.green, col_r.mid.green, col_r.bot.green, row_en);
      csum.blue  = chan_sum(col_r.top.blue,  col_r.mid.blue,  col_r.bot.blue,  row_en);
    end
  end

endmodule

>>> design/bb_line_buf.sv
// Two line stores with registered read and forwarding for one-pixel rows
module bb_line_buf
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int COL_W     = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  rgb_t             wr_pix,
  output rgb_t             top_pix,
  output rgb_t             mid_pix
);

  rgb_t upper_mem [MAX_WIDTH];
  rgb_t middle_mem [MAX_WIDTH];

  rgb_t             up_rd_r;
  rgb_t             mid_rd_r;
  rgb_t             fwd_pix_r;
  logic             fwd_r;
  logic             wr_pend_r;
  logic [COL_W-1:0] wr_addr_r;

  // middle store is written with the new pixel at the beat; upper store
  // gets the old middle entry in the cycle after the beat
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mid_rd_r            <= middle_mem[rd_addr];
      middle_mem[rd_addr] <= wr_pix;
      up_rd_r             <= upper_mem[rd_addr];
    end
    if (wr_pend_r) begin
      upper_mem[wr_addr_r] <= mid_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      wr_pend_r <= rd_en;
      if (rd_en) begin
        fwd_r <= wr_pend_r && (wr_addr_r == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      wr_addr_r <= rd_addr;
      fwd_pix_r <= mid_rd_r;
    end
  end

  assign top_pix = fwd_r ? fwd_pix_r : up_rd_r;
  assign mid_pix = mid_rd_r;

endmodule

>>> design/bb_out_fifo.sv
// Result queue between the blur pipeline and the output channel
module bb_out_fifo
  import bb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  result_t              mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r;
  logic [OUT_PTR_W-1:0] rd_ptr_r;
  logic [OUT_CNT_W-1:0] cnt_r;
  logic                 pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
  end

endmodule
